// ===== hdl/sax_pkg.sv =====
// ----------------------------------------------------------------------------
// sax_pkg
// Types, constants and the byte fold function of the shift-add-xor hash.
// ----------------------------------------------------------------------------
package sax_pkg;

	localparam int unsigned ACC_W  = 32;
	localparam int unsigned SIZE_W = 31;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CNT_W  = 5;

	localparam logic [ACC_W-1:0]  HASH_SEED  = 32'd11;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 31'd13;
	localparam logic [CNT_W-1:0]  LAST_STEP  = 5'd31;

	typedef logic [ACC_W-1:0]  acc_t;
	typedef logic [SIZE_W-1:0] size_t;
	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic fold;      // fold the byte of the accepted transaction
		logic finish;    // token ends: latch magnitude, reseed accumulator
		logic div_step;  // one remainder step
		logic out_load;  // move the remainder into the output register
	} cmd_t;

	// acc ^ ((acc << 5) + (acc >>> 2) + b), wrapping at 32 bits
	function automatic acc_t fold_byte(input acc_t acc, input byte_t b);
		acc_t shl;
		acc_t sra;
		acc_t sum;
		shl = {acc[ACC_W-6:0], 5'b0};
		sra = {{2{acc[ACC_W-1]}}, acc[ACC_W-1:2]};
		sum = shl + sra + {{(ACC_W-BYTE_W){1'b0}}, b};
		return acc ^ sum;
	endfunction

endpackage

// ===== hdl/sax_if.sv =====
// ----------------------------------------------------------------------------
// sax_in_if / sax_out_if
// Valid/ready channels for token bytes and bucket results.
// ----------------------------------------------------------------------------
interface sax_in_if;
	logic           valid;
	logic           ready;
	sax_pkg::byte_t byte_value;
	logic           has_byte;
	logic           last_byte;

	modport source (output valid, output byte_value, output has_byte, output last_byte,
		input ready);
	modport sink (input valid, input byte_value, input has_byte, input last_byte,
		output ready);
endinterface

interface sax_out_if;
	logic           valid;
	logic           ready;
	sax_pkg::size_t bucket_index;

	modport source (output valid, output bucket_index, input ready);
	modport sink (input valid, input bucket_index, output ready);
endinterface

// ===== hdl/shift_add_xor_string_hash.sv =====
// ----------------------------------------------------------------------------
// shift_add_xor_string_hash
// Shift-add-xor string hash with bucket reduction modulo a configured size.
// ----------------------------------------------------------------------------
// A token enters one byte per transaction; a byte that does not end the token
// is folded in the cycle it is accepted, so bytes stream at one per cycle while
// the block is idle. The transaction marked last_byte starts a 32-step
// restoring remainder unit that reduces the accumulator magnitude modulo the
// bucket count, one quotient bit per cycle; after a token end the next
// transaction waits for the 32 steps, the load of the result register and the
// return to idle, later if the previous result has not yet been taken. The
// result register holds one bucket_index until the sink takes it. The bucket
// count resets to 13; the user writes it through cfg_we/cfg_wdata only while
// the block is idle, which it does not enforce; a size of zero gives bucket 0.
module shift_add_xor_string_hash (
	input  logic                  clk,
	input  logic                  arst_n,
	sax_in_if.sink                token,
	sax_out_if.source             bucket,
	input  logic                  cfg_we,
	input  logic [30:0]           cfg_wdata
);

	sax_pkg::cmd_t cmd;

	sax_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (token.valid),
		.in_has    (token.has_byte),
		.in_last   (token.last_byte),
		.in_ready  (token.ready),
		.out_ready (bucket.ready),
		.out_valid (bucket.valid),
		.cmd       (cmd)
	);

	sax_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.byte_value   (token.byte_value),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.bucket_index (bucket.bucket_index)
	);

endmodule

// ===== hdl/sax_ctrl.sv =====
// ----------------------------------------------------------------------------
// sax_ctrl
// Controller: sequences byte folds, the remainder steps and the result hand-off.
// ----------------------------------------------------------------------------
module sax_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_has,
	input  logic          in_last,
	output logic          in_ready,
	input  logic          out_ready,
	output logic          out_valid,
	output sax_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t        state_q;
	sax_pkg::cnt_t count_q;
	logic          out_valid_q;
	logic          in_fire;
	logic          out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.fold     = in_fire && in_has;
		cmd.finish   = in_fire && in_last;
		cmd.div_step = (state_q == ST_DIV);
		cmd.out_load = (state_q == ST_FIN) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.finish) begin
						count_q <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					count_q <= count_q + 1'b1;
					if (count_q == sax_pkg::LAST_STEP) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_accept_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> !in_ready)
		else $error("token accepted during remainder steps");
	a_token_end_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (state_q == ST_DIV) && (count_q == '0))
		else $error("token end did not start the remainder unit");
	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) && (count_q == sax_pkg::LAST_STEP) |=> (state_q == ST_FIN))
		else $error("remainder unit overran its step count");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> !$past(cmd.out_load))
		else $error("pending result overwritten");
`endif

endmodule

// ===== hdl/sax_dp.sv =====
// ----------------------------------------------------------------------------
// sax_dp
// Datapath: accumulator, table size register, restoring remainder unit and
// result register.
// ----------------------------------------------------------------------------
module sax_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  sax_pkg::cmd_t  cmd,
	input  sax_pkg::byte_t byte_value,
	input  logic           cfg_we,
	input  sax_pkg::size_t cfg_wdata,
	output sax_pkg::size_t bucket_index
);

	sax_pkg::acc_t  acc_q;
	sax_pkg::size_t size_q;
	sax_pkg::acc_t  mag_q;
	sax_pkg::size_t rem_q;
	sax_pkg::size_t bucket_q;
	sax_pkg::acc_t  acc_next;
	sax_pkg::acc_t  acc_abs;
	sax_pkg::acc_t  trial;
	sax_pkg::acc_t  diff;
	sax_pkg::size_t rem_next;

	assign acc_next = cmd.fold ? sax_pkg::fold_byte(acc_q, byte_value) : acc_q;
	// most negative value maps to 2^31, which fits the unsigned 32-bit word
	assign acc_abs  = acc_next[sax_pkg::ACC_W-1] ? (~acc_next + 1'b1) : acc_next;

	// shift in the next dividend bit, subtract the size when it fits
	assign trial    = {rem_q, mag_q[sax_pkg::ACC_W-1]};
	assign diff     = trial - {1'b0, size_q};
	assign rem_next = (trial >= {1'b0, size_q}) ? diff[sax_pkg::SIZE_W-1:0]
		: trial[sax_pkg::SIZE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= sax_pkg::HASH_SEED;
			size_q <= sax_pkg::SIZE_RESET;
		end else begin
			if (cfg_we) begin
				size_q <= cfg_wdata;
			end
			if (cmd.finish) begin
				acc_q <= sax_pkg::HASH_SEED;
			end else if (cmd.fold) begin
				acc_q <= acc_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			mag_q <= acc_abs;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			mag_q <= {mag_q[sax_pkg::ACC_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
		if (cmd.out_load) begin
			bucket_q <= (size_q == '0) ? '0 : rem_q;
		end
	end

	assign bucket_index = bucket_q;

endmodule
